### hw/rtl/lfd_pkg.sv
package lfd_pkg;

	localparam int HEADER_BYTES     = 12;
	localparam int HEADER_CRC_BYTES = 8;
	localparam int LEN_W            = 25;
	localparam int CFG_IDX_W        = 1;

	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam logic [LEN_W-1:0] MIN_LEN_RESET = LEN_W'(1);
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(1048576);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'b1;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_CORRUPT    = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_BUSY       = 2'd3
	} status_t;

	// One result beat as it sits in the output register.
	typedef struct packed {
		status_t     status;
		logic        frame_done;
		logic        out_byte_valid;
		logic [7:0]  out_byte;
	} result_t;

endpackage

### hw/rtl/lfd_crc_byte.sv
// Reflected CRC-32C update by one byte, no final inversion.
module lfd_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ lfd_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule

### hw/rtl/log_frame_deframer_crc32c.sv
// Path: an accepted input beat is held in the input register while it is parsed, and its result
// beat is then presented on the master side from the result register (one input register, one
// result register); while the master side stalls, both registers hold.
// Throughput: one input beat per cycle, sustained, as long as the master side takes its beats;
// the byte-wide CRC-32C update and the header checks each fit in the single parse stage.
// Reset: arst_n clears the control and frame state at once, not the data registers; the parser
// starts in the header phase with the length limits at their defaults (minimum 1, maximum 1048576).
module log_frame_deframer_crc32c (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_input

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // frame_done
	output logic [2:0]  m_tuser,   // [0] out_byte_valid, [2:1] status

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfd_pkg::LEN_W-1:0]        cfg_data
);

	localparam int LW = lfd_pkg::LEN_W;

	// Configuration registers. The user must write them only while the block is idle; the block
	// itself does not enforce this, and writes are always taken.
	logic [LW-1:0] min_len_q, max_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= lfd_pkg::MIN_LEN_RESET;
			max_len_q <= lfd_pkg::MAX_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lfd_pkg::REG_MIN_LEN: min_len_q <= cfg_data;
				lfd_pkg::REG_MAX_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register. It takes a new beat whenever it is empty or the parse stage can hand its result on.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       advance;
	logic       out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	// Frame state.
	lfd_pkg::phase_t phase_q, phase_nxt;
	logic [LW-1:0]   count_q, count_nxt;
	logic [31:0]     length_q, length_nxt;
	logic [31:0]     pcrc_q, pcrc_nxt;     // expected payload CRC from the header
	logic [31:0]     hcrc_q, hcrc_nxt;     // expected header CRC from the header
	logic [31:0]     hres_q, hres_nxt;     // CRC computed over the first eight header bytes
	logic [31:0]     crc_q, crc_nxt;       // running CRC register

	logic [31:0] crc_upd;

	lfd_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (byte_s1),
		.crc_out (crc_upd)
	);

	// Decode of the current byte against the state.
	logic [3:0]  hdr_idx;
	logic [31:0] ins;
	logic [31:0] len_upd, pcrc_upd, hcrc_upd;
	logic [4:0]  hdr_cnt_nxt;
	logic        hdr_done, hdr_bad, len_zero;
	logic [LW-1:0] pay_cnt_nxt;
	logic        pay_last, pay_ok;

	always_comb begin
		hdr_idx     = count_q[3:0];
		ins         = {24'd0, byte_s1} << {hdr_idx[1:0], 3'b000};
		len_upd     = length_q;
		pcrc_upd    = pcrc_q;
		hcrc_upd    = hcrc_q;
		unique case (hdr_idx[3:2])
			2'd0:    len_upd  = length_q | ins;
			2'd1:    pcrc_upd = pcrc_q | ins;
			default: hcrc_upd = hcrc_q | ins;
		endcase
		hdr_cnt_nxt = {1'b0, hdr_idx} + 5'd1;
		hdr_done    = hdr_cnt_nxt >= 5'(lfd_pkg::HEADER_BYTES);
		hdr_bad     = (hcrc_upd != hres_q) || (len_upd < {7'd0, min_len_q})
		              || (len_upd > {7'd0, max_len_q});
		len_zero    = len_upd == 32'd0;
		pay_cnt_nxt = count_q + LW'(1);
		pay_last    = {7'd0, pay_cnt_nxt} >= length_q;
		pay_ok      = ~crc_upd == pcrc_q;
	end

	// Next state.
	always_comb begin
		logic restart;
		restart    = 1'b0;
		phase_nxt  = phase_q;
		count_nxt  = count_q;
		length_nxt = length_q;
		pcrc_nxt   = pcrc_q;
		hcrc_nxt   = hcrc_q;
		hres_nxt   = hres_q;
		crc_nxt    = crc_q;
		unique case (phase_q)
			lfd_pkg::PH_DISCARD: begin
				restart = eoi_s1;
			end
			lfd_pkg::PH_PAYLOAD: begin
				crc_nxt   = crc_upd;
				count_nxt = pay_cnt_nxt;
				restart   = pay_last || eoi_s1;
			end
			default: begin
				// Header phase; the unused phase code behaves the same way.
				length_nxt = len_upd;
				pcrc_nxt   = pcrc_upd;
				hcrc_nxt   = hcrc_upd;
				count_nxt  = LW'(hdr_cnt_nxt);
				if (hdr_idx < 4'(lfd_pkg::HEADER_CRC_BYTES)) begin
					crc_nxt = crc_upd;
					if (hdr_idx == 4'(lfd_pkg::HEADER_CRC_BYTES - 1)) begin
						hres_nxt = ~crc_upd;
						crc_nxt  = lfd_pkg::CRC_INIT;
					end
				end
				priority if (!hdr_done) begin
					restart = eoi_s1;
				end else if (hdr_bad) begin
					restart   = eoi_s1;
					phase_nxt = lfd_pkg::PH_DISCARD;
				end else if (len_zero || eoi_s1) begin
					restart = 1'b1;
				end else begin
					phase_nxt = lfd_pkg::PH_PAYLOAD;
					count_nxt = '0;
					crc_nxt   = lfd_pkg::CRC_INIT;
				end
			end
		endcase
		if (restart) begin
			phase_nxt  = lfd_pkg::PH_HEADER;
			count_nxt  = '0;
			length_nxt = '0;
			pcrc_nxt   = '0;
			hcrc_nxt   = '0;
			hres_nxt   = '0;
			crc_nxt    = lfd_pkg::CRC_INIT;
		end
	end

	// Result of the current byte.
	logic              emit;
	lfd_pkg::result_t  res;

	always_comb begin
		emit               = 1'b0;
		res.out_byte       = 8'd0;
		res.out_byte_valid = 1'b0;
		res.frame_done     = 1'b0;
		res.status         = lfd_pkg::ST_BUSY;
		unique case (phase_q)
			lfd_pkg::PH_DISCARD: begin
				emit = 1'b0;
			end
			lfd_pkg::PH_PAYLOAD: begin
				emit               = 1'b1;
				res.out_byte       = byte_s1;
				res.out_byte_valid = 1'b1;
				priority if (pay_last) begin
					res.frame_done = 1'b1;
					res.status     = pay_ok ? lfd_pkg::ST_OK : lfd_pkg::ST_CORRUPT;
				end else if (eoi_s1) begin
					res.frame_done = 1'b1;
					res.status     = lfd_pkg::ST_INCOMPLETE;
				end else begin
					res.frame_done = 1'b0;
				end
			end
			default: begin
				res.frame_done = 1'b1;
				priority if (!hdr_done) begin
					emit       = eoi_s1;
					res.status = lfd_pkg::ST_INCOMPLETE;
				end else if (hdr_bad) begin
					emit       = 1'b1;
					res.status = lfd_pkg::ST_CORRUPT;
				end else if (len_zero) begin
					// An empty payload has CRC-32C zero.
					emit       = 1'b1;
					res.status = (pcrc_upd == 32'd0) ? lfd_pkg::ST_OK : lfd_pkg::ST_CORRUPT;
				end else begin
					emit       = eoi_s1;
					res.status = lfd_pkg::ST_INCOMPLETE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lfd_pkg::PH_HEADER;
			count_q  <= '0;
			length_q <= '0;
			pcrc_q   <= '0;
			hcrc_q   <= '0;
			hres_q   <= '0;
			crc_q    <= lfd_pkg::CRC_INIT;
		end else if (advance) begin
			phase_q  <= phase_nxt;
			count_q  <= count_nxt;
			length_q <= length_nxt;
			pcrc_q   <= pcrc_nxt;
			hcrc_q   <= hcrc_nxt;
			hres_q   <= hres_nxt;
			crc_q    <= crc_nxt;
		end
	end

	// Output register.
	lfd_pkg::result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.out_byte;
	assign m_tlast  = out_q.frame_done;
	assign m_tuser  = {out_q.status, out_q.out_byte_valid};

`ifndef NO_ASSERTIONS
	// A beat that does not close a frame always reports the frame as in progress.
	a_open_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[2:1] == lfd_pkg::ST_BUSY)
		else $error("open frame beat with a final status");

	// Beats without a payload byte carry a zero byte.
	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
		else $error("nonzero byte on a status-only beat");

	// In the payload phase the length is nonzero and the count has not reached it.
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lfd_pkg::PH_PAYLOAD |-> length_q != 32'd0 && {7'd0, count_q} < length_q)
		else $error("payload count out of range");

	// A result produced by the parse stage shows up on the master side next cycle.
	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> m_tvalid)
		else $error("result beat lost");
`endif

endmodule
